@@ design/mpts_pkg.sv @@
// Package for the maze path turn simplifier.
// Holds turn and item-kind codes and the stream beat layouts.
// No dependencies.
package mpts_pkg;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_RIGHT    = 2'd1,
    TURN_BACK     = 2'd2,
    TURN_LEFT     = 2'd3
  } turn_t;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  localparam int IDX_W       = 7;
  localparam int LEN_W       = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // input tdata layout
  localparam int IN_CODE_LSB = 0;
  localparam int IN_IDX_LSB  = 2;
  localparam int IN_USED_W   = 9;

  // output tdata layout
  localparam int OUT_USED_W  = 13;

endpackage

@@ design/mpts_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// Read-first on an address collision. No dependencies.
module mpts_ram #(
  parameter int WIDTH  = 2,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ design/maze_path_turn_simplifier.sv @@
// Maze path turn simplifier, top level.
// Depends on mpts_pkg and mpts_ram.
//
// Usage:
//   in_*  : one beat per item. in_tuser = kind (0 record a turn, 1 read a stored turn).
//           in_tdata = turn_code, read_index.
//   out_* : one beat per item, in order. out_tdata = path_length, read_turn,
//           read_valid, simplified, overflow.
//   cfg_* : write of recording_frozen (bit 0 of cfg_data); cfg_ready is always high.
//           Write only while no item is in flight.
// Turns live in a PATH_DEPTH x 2 RAM. On acceptance the RAM reads the top two
// stack entries (or the requested entry for a read) using the stack depth the
// item will see; once the item leaves the input register, one short piece of
// logic pushes, reduces (back turn second from top: the three codes summed
// mod 4 replace the third), flags overflow or reads, and the result register loads.
// Throughput: one item per cycle unless a low out_tready holds the result
// register, limited by the single RAM write port (at most one write per item).
// Reset: stack empty, recording enabled; RAM contents are not cleared and no
// clearing pass runs. When out_tready is low the result register holds, the
// input register still fills, and in_tready drops only once both are occupied.
module maze_path_turn_simplifier #(
  parameter int PATH_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] turn_code, [8:2] read_index, [15:9] zero
  input  logic [mpts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] kind
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] path_length, [9:8] read_turn, [10] read_valid, [11] simplified,
  // [12] overflow, [15:13] zero
  output logic [mpts_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);

  import mpts_pkg::*;

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int WW = (CW > IDX_W) ? CW : IDX_W;
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  // ---------------- configuration
  logic frozen_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r <= 1'b0;
    end else if (cfg_valid) begin
      frozen_r <= cfg_data;
    end
  end

  // ---------------- input beat fields
  logic [1:0]       in_code;
  logic [IDX_W-1:0] in_idx;
  logic             in_kind;
  logic [IW-1:0]    in_idx_w;
  logic             in_fire;

  assign in_code  = in_tdata[IN_CODE_LSB +: 2];
  assign in_idx   = in_tdata[IN_IDX_LSB +: IDX_W];
  assign in_kind  = in_tuser[0];
  assign in_idx_w = IW'(in_idx);
  assign in_fire  = in_tvalid && in_tready;

  // ---------------- state
  logic [CW-1:0]    cnt_r, cnt_nxt, cnt_vis, cnt_m1, cnt_m2, cnt_fold;
  logic             inq_valid_r;
  logic             inq_kind_r;
  logic [1:0]       inq_code_r;
  logic [IDX_W-1:0] inq_idx_r;
  logic             byp_a_r, byp_b_r;
  logic [1:0]       byp_d_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic             proc_fire;

  assign proc_fire = inq_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !inq_valid_r || proc_fire;

  // ---------------- RAM
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [1:0]    ram_a, ram_b;

  // addresses use the depth the incoming item will see
  assign cnt_vis   = proc_fire ? cnt_nxt : cnt_r;
  assign cnt_m1    = cnt_vis - CW'(1);
  assign cnt_m2    = cnt_vis - CW'(2);
  assign rd_addr_a = (in_kind == KIND_READ) ? in_idx_w[AW-1:0] : cnt_m1[AW-1:0];
  assign rd_addr_b = cnt_m2[AW-1:0];

  mpts_ram #(
    .WIDTH (2),
    .DEPTH (PATH_DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .re     (in_fire),
    .raddr_a(rd_addr_a),
    .raddr_b(rd_addr_b),
    .rdata_a(ram_a),
    .rdata_b(ram_b)
  );

  // ---------------- input register; bypass of the write landing on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_fire) begin
      inq_valid_r <= 1'b1;
    end else if (proc_fire) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_kind_r <= in_kind;
      inq_code_r <= in_code;
      inq_idx_r  <= in_idx;
      byp_a_r    <= wr_en && (wr_addr == rd_addr_a);
      byp_b_r    <= wr_en && (wr_addr == rd_addr_b);
      byp_d_r    <= wr_data;
    end
  end

  // ---------------- item logic
  logic [1:0]    top_turn, sec_turn, sum_turn;
  logic [WW-1:0] idx_cmp, cnt_cmp;
  logic [XW-1:0] len_x;
  logic          res_valid, res_simp, res_ovf;
  logic [1:0]    res_turn;

  assign top_turn = byp_a_r ? byp_d_r : ram_a;
  assign sec_turn = byp_b_r ? byp_d_r : ram_b;
  assign sum_turn = sec_turn + 2'(TURN_BACK) + inq_code_r;
  assign idx_cmp  = WW'(inq_idx_r);
  assign cnt_cmp  = WW'(cnt_r);
  assign cnt_fold = cnt_r - CW'(2);

  always_comb begin
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = inq_code_r;
    res_valid = 1'b0;
    res_turn  = 2'd0;
    res_simp  = 1'b0;
    res_ovf   = 1'b0;
    if (inq_kind_r == KIND_READ) begin
      if (idx_cmp < cnt_cmp) begin
        res_valid = 1'b1;
        res_turn  = top_turn;
      end
    end else if (!frozen_r) begin
      if (cnt_r == CW'(PATH_DEPTH)) begin
        res_ovf = 1'b1;
      end else if (cnt_r >= CW'(2) && top_turn == TURN_BACK) begin
        // back turn second from top after the push: fold three into one
        wr_en    = proc_fire;
        wr_addr  = cnt_fold[AW-1:0];
        wr_data  = sum_turn;
        cnt_nxt  = cnt_r - CW'(1);
        res_simp = 1'b1;
      end else begin
        wr_en   = proc_fire;
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    len_x        = XW'(cnt_nxt);
    out_data_nxt = {3'b000, res_ovf, res_simp, res_valid, res_turn, len_x[LEN_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (proc_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PATH_DEPTH))
    else $error("stack depth above PATH_DEPTH");

  a_simp_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && res_simp |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("reduction did not net one entry less");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && res_ovf |=> cnt_r == CW'(PATH_DEPTH))
    else $error("overflow flagged with room on the stack");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_data_r[OUT_USED_W-1:LEN_W+2]))
    else $error("more than one of read_valid, simplified, overflow set");

  a_no_write_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    frozen_r && inq_kind_r == KIND_RECORD |-> !wr_en)
    else $error("stack written while recording is frozen");

endmodule

@@ sim/tb.sv @@
// Testbench for maze_path_turn_simplifier: streams record and read beats, predicts
// every result beat with a local turn-stack model held in a small scoreboard class.
// Depends on mpts_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
  import mpts_pkg::*;

  localparam int DEPTH     = 128;
  localparam int LIMIT     = 300000;
  localparam int HOLD_AT   = 500;
  localparam int HOLD_LEN  = 400;

  // result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]       pad;
    logic             overflow;
    logic             simplified;
    logic             read_valid;
    logic [1:0]       read_turn;
    logic [LEN_W-1:0] path_length;
  } result_t;

  class turn_stack_board;
    turn_t       turns[DEPTH];
    int unsigned depth;
    bit          frozen;
    result_t     due_results[$];
    int          fails;
    int          accepted;

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      fails++;
    endtask

    function int pending();
      return due_results.size();
    endfunction

    // Update the stack for one accepted item and queue the beat it should produce.
    function void apply_item(kind_t k, turn_t code, logic [IDX_W-1:0] idx);
      result_t    r;
      logic [3:0] sum;
      r = '0;
      accepted++;
      if (k == KIND_RECORD) begin
        if (!frozen) begin
          if (depth == DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            turns[depth] = code;
            depth++;
            if (depth >= 3 && turns[depth-2] == TURN_BACK) begin
              sum = 4'(turns[depth-1]) + 4'(turns[depth-2]) + 4'(turns[depth-3]);
              turns[depth-3] = turn_t'(sum[1:0]);
              depth -= 2;
              r.simplified = 1'b1;
            end
          end
        end
      end else if (idx < depth) begin
        r.read_valid = 1'b1;
        r.read_turn  = turns[idx];
      end
      r.path_length = depth[LEN_W-1:0];
      due_results.push_back(r);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat);
      if (due_results.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", beat));
      end else begin
        want = due_results.pop_front();
        if (got.path_length !== want.path_length)
          report($sformatf("path_length %0d, expected %0d", got.path_length, want.path_length));
        if (got.read_turn !== want.read_turn)
          report($sformatf("read_turn %0d, expected %0d", got.read_turn, want.read_turn));
        if (got.read_valid !== want.read_valid)
          report($sformatf("read_valid %b, expected %b", got.read_valid, want.read_valid));
        if (got.simplified !== want.simplified)
          report($sformatf("simplified %b, expected %b", got.simplified, want.simplified));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
        if (got.pad !== want.pad)
          report($sformatf("pad bits %b, expected zero", got.pad));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [1:0] turn_code, [8:2] read_index, [15:9] zero
  logic [0:0]             in_tuser;   // [0] kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] path_length, [9:8] read_turn, [10] read_valid,
                                      // [11] simplified, [12] overflow, [15:13] zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;

  turn_stack_board board = new;
  int  cycles;
  int  burst_left;
  bit  held;

  maze_path_turn_simplifier #(.PATH_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // handshakes are sampled at the falling edge, where every signal is settled
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata);
  end

  task send_item(kind_t k, turn_t code, logic [IDX_W-1:0] idx);
    int gap;
    bit acc;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-IN_USED_W){1'b0}}, idx, code};
    in_tuser  <= k;
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    board.apply_item(k, code, idx);
  endtask

  task write_frozen(bit value);
    bit acc;
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    board.frozen = value;
  endtask

  task run_phase(bit frozen, int count, int back_pct, int read_pct);
    kind_t            k;
    turn_t            code;
    logic [IDX_W-1:0] idx;
    int               top;
    write_frozen(frozen);
    repeat (count) begin
      k = ($urandom_range(0, 99) < read_pct) ? KIND_READ : KIND_RECORD;
      if ($urandom_range(0, 99) < back_pct)
        code = TURN_BACK;
      else
        case ($urandom_range(0, 2))
          0:       code = TURN_STRAIGHT;
          1:       code = TURN_RIGHT;
          default: code = TURN_LEFT;
        endcase
      top = (board.depth + 1 > 127) ? 127 : board.depth + 1;
      if (k == KIND_READ && $urandom_range(0, 99) < 70)
        idx = IDX_W'($urandom_range(0, top));
      else
        idx = IDX_W'($urandom_range(0, 127));
      send_item(k, code, idx);
    end
  endtask

  // receiver: stretches of differing stall density, plus one long hold-off
  initial begin
    int mode;
    int len;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && board.accepted >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(20, 150);
        repeat (len) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= $urandom_range(0, 1);
            2:       out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    cycles     = 0;
    burst_left = 0;
    held       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reads of an empty stack, both reduction orders, index extremes
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd0);
    send_item(KIND_RECORD, TURN_STRAIGHT, 7'd0);
    send_item(KIND_RECORD, TURN_RIGHT,    7'd0);
    send_item(KIND_RECORD, TURN_BACK,     7'd0);
    send_item(KIND_RECORD, TURN_LEFT,     7'd127);   // R B L folds to B
    send_item(KIND_RECORD, TURN_LEFT,     7'd0);     // S B L folds to R
    send_item(KIND_READ,   TURN_LEFT,     7'd0);
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd1);
    send_item(KIND_READ,   TURN_BACK,     7'd127);
    send_item(KIND_RECORD, TURN_BACK,     7'd0);
    send_item(KIND_RECORD, TURN_BACK,     7'd0);     // R B B folds to R
    send_item(KIND_RECORD, TURN_LEFT,     7'd0);
    send_item(KIND_RECORD, TURN_STRAIGHT, 7'd0);
    send_item(KIND_RECORD, TURN_RIGHT,    7'd0);
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd3);
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd4);
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd64);
    write_frozen(1'b1);
    send_item(KIND_RECORD, TURN_BACK,     7'd0);     // ignored while frozen
    send_item(KIND_RECORD, TURN_LEFT,     7'd0);
    send_item(KIND_READ,   TURN_STRAIGHT, 7'd1);
    write_frozen(1'b0);
    send_item(KIND_RECORD, TURN_BACK,     7'd0);
    send_item(KIND_RECORD, TURN_STRAIGHT, 7'd0);

    // random: phases rich in back turns first, then one with few that fills the stack and keeps it full
    run_phase(1'b0, 350, 30, 30);
    run_phase(1'b1, 100, 30, 40);
    run_phase(1'b0, 350, 25, 30);
    run_phase(1'b0, 350,  6, 20);
    run_phase(1'b1,  80, 30, 30);
    run_phase(1'b0, 120, 30, 30);

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.fails == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
